// ===== design/fir_q31_pkg.sv =====
// ----------------------------------------------------------------------------
// fir_q31_pkg
// shared constants and controller/datapath interface types of the q31 fir
// ----------------------------------------------------------------------------
package fir_q31_pkg;

  // filter length, 2 to 1024
  localparam int unsigned TAPS = 1024;
  localparam int unsigned IDX_W = (TAPS > 1) ? $clog2(TAPS) : 1;

  // field widths
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned COEF_W = 32;
  localparam int unsigned COEF_IDX_W = 10;
  localparam int unsigned ACC_W = 64;
  localparam int unsigned COEF_SHIFT = 28;

  // stream packing
  localparam int unsigned IN_DATA_W = 80;
  localparam int unsigned OUT_DATA_W = 32;

  // item kinds carried in tuser
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_COEF = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic clr_en;    // write zero to both stores at the sweep address
    logic coef_wr;   // store the incoming coefficient
    logic push;      // enter the incoming sample, restart the tap sweep
    logic mac_step;  // issue one tap read
    logic emit;      // load the output register
  } fir_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cnt_last;    // sweep counter on its last tap
    logic pipe_empty;  // no tap in flight through read and multiply
    logic out_free;    // output register can take a result
  } fir_sts_t;

endpackage

// ===== design/fir_q31_dp.sv =====
// ----------------------------------------------------------------------------
// fir_q31_dp
// sample history, coefficient store, multiply-accumulate pipe and output stage
// ----------------------------------------------------------------------------
module fir_q31_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  fir_q31_pkg::fir_cmd_t                  cmd_i,
  output fir_q31_pkg::fir_sts_t                  sts_o,
  input  logic [fir_q31_pkg::SAMPLE_W-1:0]       sample_i,
  input  logic [fir_q31_pkg::COEF_IDX_W-1:0]     coef_index_i,
  input  logic [fir_q31_pkg::COEF_W-1:0]         coef_value_i,
  input  logic                                   out_ready_i,
  output logic                                   out_valid_o,
  output logic [fir_q31_pkg::OUT_DATA_W-1:0]     out_data_o
);

  localparam int unsigned IW = fir_q31_pkg::IDX_W;
  localparam int unsigned AW = fir_q31_pkg::ACC_W;
  localparam int unsigned SH = fir_q31_pkg::COEF_SHIFT;
  localparam int unsigned OW = fir_q31_pkg::OUT_DATA_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(fir_q31_pkg::TAPS - 1);

  logic [fir_q31_pkg::SAMPLE_W-1:0] hist_mem [fir_q31_pkg::TAPS];
  logic [fir_q31_pkg::COEF_W-1:0]   coef_mem [fir_q31_pkg::TAPS];

  logic [IW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] pos_q, pos_d;
  logic [IW-1:0] newest_q, newest_d;
  logic          rd_vld_q, prod_vld_q;
  logic [fir_q31_pkg::SAMPLE_W-1:0] hist_rd_q;
  logic [fir_q31_pkg::COEF_W-1:0]   coef_rd_q;
  logic signed [AW-1:0] prod_q;
  logic [AW-1:0] acc_q, acc_d;
  logic          out_vld_q, out_vld_d;
  logic [OW-1:0] out_data_q, out_data_d;
  logic          cnt_last;
  logic          coef_ok;
  logic          in_range;
  logic [OW-1:0] sat_val;

  assign cnt_last = (cnt_q == LAST_IDX);
  assign coef_ok  = (32'(coef_index_i) < 32'(fir_q31_pkg::TAPS));

  // new sample goes one slot below the previous newest, wrapping
  assign newest_d = (newest_q == '0) ? LAST_IDX : newest_q - IW'(1);

  always_comb begin
    cnt_d = cnt_q;
    pos_d = pos_q;
    if (cmd_i.push) begin
      cnt_d = '0;
      pos_d = newest_d;
    end else if (cmd_i.clr_en || cmd_i.mac_step) begin
      cnt_d = cnt_last ? '0 : cnt_q + IW'(1);
      pos_d = (pos_q == LAST_IDX) ? '0 : pos_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      pos_q      <= '0;
      newest_q   <= '0;
      rd_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      pos_q      <= pos_d;
      rd_vld_q   <= cmd_i.mac_step;
      prod_vld_q <= rd_vld_q;
      out_vld_q  <= out_vld_d;
      if (cmd_i.push) begin
        newest_q <= newest_d;
      end
    end
  end

  // history store: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_en) begin
      hist_mem[cnt_q] <= '0;
    end else if (cmd_i.push) begin
      hist_mem[newest_d] <= sample_i;
    end
    hist_rd_q <= hist_mem[pos_q];
  end

  // coefficient store: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_en) begin
      coef_mem[cnt_q] <= '0;
    end else if (cmd_i.coef_wr && coef_ok) begin
      coef_mem[IW'(coef_index_i)] <= coef_value_i;
    end
    coef_rd_q <= coef_mem[cnt_q];
  end

  // multiply then accumulate, wraps modulo 2^64
  always_comb begin
    acc_d = acc_q;
    if (cmd_i.push) begin
      acc_d = '0;
    end else if (prod_vld_q) begin
      acc_d = acc_q + AW'(prod_q);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= AW'(signed'(hist_rd_q) * signed'(coef_rd_q));
    acc_q  <= acc_d;
  end

  // shift by 28 and saturate: in range when the bits above the kept word agree with its sign bit
  assign in_range = (acc_q[AW-1:SH+OW-1] == '0) || (acc_q[AW-1:SH+OW-1] == '1);

  always_comb begin
    if (in_range) begin
      sat_val = acc_q[SH+OW-1:SH];
    end else if (acc_q[AW-1]) begin
      sat_val = {1'b1, {(OW-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(OW-1){1'b1}}};
    end
  end

  always_comb begin
    out_vld_d  = out_vld_q;
    out_data_d = out_data_q;
    if (cmd_i.emit) begin
      out_vld_d  = 1'b1;
      out_data_d = sat_val;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;

  assign sts_o.cnt_last   = cnt_last;
  assign sts_o.pipe_empty = !rd_vld_q && !prod_vld_q;
  assign sts_o.out_free   = !out_vld_q || out_ready_i;

  // a tap read always reaches the multiplier output in the next cycle
  a_pipe_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |=> prod_vld_q)
    else $error("tap lost between read and multiply");

  // a result is only taken from a fully drained accumulator
  a_emit_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!rd_vld_q && !prod_vld_q))
    else $error("result emitted with taps in flight");

  // a new sample never restarts the sweep under a running one
  a_push_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> (!rd_vld_q && !prod_vld_q && !cmd_i.mac_step))
    else $error("sample entered during a sweep");

  // emit never overwrites a result that was not taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_vld_q || out_ready_i))
    else $error("pending result overwritten");

endmodule

// ===== design/fir_q31_ctrl.sv =====
// ----------------------------------------------------------------------------
// fir_q31_ctrl
// sequencer: store clearing, item intake, tap sweep, drain and result hand-off
// ----------------------------------------------------------------------------
module fir_q31_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_mode_i,
  output logic                  in_ready_o,
  input  fir_q31_pkg::fir_sts_t sts_i,
  output fir_q31_pkg::fir_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_MAC   = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_EMIT  = 5'b10000
  } fir_state_e;

  fir_state_e state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_mode_i == fir_q31_pkg::MODE_COEF) begin
            cmd_o.coef_wr = 1'b1;
          end else begin
            cmd_o.push = 1'b1;
            state_d    = ST_MAC;
          end
        end
      end
      ST_MAC: begin
        cmd_o.mac_step = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (sts_i.pipe_empty) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // a sweep always ends through drain and emit before new intake
  a_mac_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAC && sts_i.cnt_last) |=> (state_q == ST_DRAIN))
    else $error("tap sweep did not end in drain");

  // nothing is taken in while the stores are being cleared
  a_clear_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> (!in_ready_o && !cmd_o.coef_wr && !cmd_o.push))
    else $error("intake during clearing pass");

  // the clearing pass is left exactly once, into idle
  a_clear_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(state_q == ST_CLEAR) |-> (state_q == ST_IDLE))
    else $error("clearing pass left into wrong state");

endmodule

// ===== design/fir_filter_q31.sv =====
// ----------------------------------------------------------------------------
// fir_filter_q31
// Direct-form FIR filter on Q1.31 samples with Q4.28 coefficients. An input
// transfer with tuser = 1 writes one coefficient (indexes at or beyond TAPS
// are dropped) without leaving the intake state and gives no output. A
// transfer with tuser = 0 enters a sample into the history and starts a
// sweep over all TAPS taps, one multiply-accumulate per cycle through a
// single 32x32 multiplier reading one history and one coefficient memory.
// The read and multiply registers then drain, and the result is loaded into
// the output register once a previous result held there has been taken.
// Coefficient 0 applies to the newest sample. The 64-bit sum wraps, is
// shifted right arithmetically by 28 and saturated to 32 bits. After reset
// both memories are swept to zero, address by address, during which
// s_axis_tready stays low. A finished result waits in an output register,
// so the next item is accepted while the previous result is still pending.
// ----------------------------------------------------------------------------
module fir_filter_q31 (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // input stream
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [31:0] sample, [41:32] coef_index, [73:42] coef_value, [79:74] zero
  input  logic [fir_q31_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // [0] mode: 0 sample, 1 coefficient write
  input  logic                                   s_axis_tuser,
  // output stream
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // [31:0] filtered_sample
  output logic [fir_q31_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

  localparam int unsigned SW = fir_q31_pkg::SAMPLE_W;
  localparam int unsigned IXW = fir_q31_pkg::COEF_IDX_W;
  localparam int unsigned CW = fir_q31_pkg::COEF_W;

  fir_q31_pkg::fir_cmd_t cmd;
  fir_q31_pkg::fir_sts_t sts;

  // unpack the input transfer
  logic [SW-1:0]  sample;
  logic [IXW-1:0] coef_index;
  logic [CW-1:0]  coef_value;

  assign sample     = s_axis_tdata[SW-1:0];
  assign coef_index = s_axis_tdata[SW+IXW-1:SW];
  assign coef_value = s_axis_tdata[SW+IXW+CW-1:SW+IXW];

  // sequencer: intake, sweep and hand-off
  fir_q31_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_mode_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // memories, mac pipe and output register
  fir_q31_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .sample_i     (sample),
    .coef_index_i (coef_index),
    .coef_value_i (coef_value),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_data_o   (m_axis_tdata)
  );

endmodule

// ===== bench/fir_filter_q31_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fir_filter_q31_test
// Self-checking bench for the q31 fir. Streams coefficient writes and samples
// into the block. A behavioral filter with its own coefficient table and
// sample history computes each output when its input transfer completes,
// and the result stream is compared against those outputs in order. The run
// has three phases: light sender gaps with heavy receiver stalls, the
// reverse, and full rate with one long output hold-off.
// ----------------------------------------------------------------------------
module fir_filter_q31_test;

  localparam int unsigned TAPS       = fir_q31_pkg::TAPS;
  localparam int unsigned SAMPLE_W   = fir_q31_pkg::SAMPLE_W;
  localparam int unsigned COEF_W     = fir_q31_pkg::COEF_W;
  localparam int unsigned COEF_IDX_W = fir_q31_pkg::COEF_IDX_W;
  localparam int unsigned ACC_W      = fir_q31_pkg::ACC_W;
  localparam int unsigned COEF_SHIFT = fir_q31_pkg::COEF_SHIFT;
  localparam int unsigned IN_DATA_W  = fir_q31_pkg::IN_DATA_W;
  localparam int unsigned OUT_DATA_W = fir_q31_pkg::OUT_DATA_W;
  localparam logic MODE_SAMPLE = fir_q31_pkg::MODE_SAMPLE;
  localparam logic MODE_COEF   = fir_q31_pkg::MODE_COEF;

  localparam int unsigned PAD_W = IN_DATA_W - SAMPLE_W - COEF_IDX_W - COEF_W;
  // one sweep plus pipeline, taken twice for the final drain
  localparam int unsigned DRAIN_CYCLES = 2 * TAPS + 16;
  // long enough to back up the output register and the sweep behind it
  localparam int unsigned HOLD_CYCLES = 4 * TAPS;
  // roughly 580 transfers at one sweep each, several times over
  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned MAX_REPORTS = 10;

  localparam longint signed Q31_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint signed Q31_MIN = 64'shFFFF_FFFF_8000_0000;

  typedef struct {
    logic                  mode;
    logic [SAMPLE_W-1:0]   sample;
    logic [COEF_IDX_W-1:0] coef_index;
    logic [COEF_W-1:0]     coef_value;
  } fir_item_t;

  // dut ports; the inputs are known from time zero
  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
  logic                   s_axis_tuser = MODE_SAMPLE;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;

  // pending input transfers and the outputs they should produce
  fir_item_t              item_q[$];
  fir_item_t              item_on_bus;
  logic [SAMPLE_W-1:0]    expected_out_q[$];

  // behavioral filter state
  logic [COEF_W-1:0]      tap_mem[TAPS];
  logic [SAMPLE_W-1:0]    hist_mem[TAPS];
  int unsigned            newest;

  // flow control knobs, changed only at falling edges
  int unsigned            src_gap_pct = 0;
  int unsigned            sink_stall_pct = 0;
  logic                   hold_go = 1'b0;
  logic                   hold_rx = 1'b0;

  int unsigned            error_count = 0;
  int unsigned            cycle_count = 0;

  fir_filter_q31 dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [31:0] sample, [41:32] coef_index, [73:42] coef_value
    .s_axis_tuser  (s_axis_tuser),   // [0] mode
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)    // [31:0] filtered_sample
  );

  always #10 clk_i = ~clk_i;

  // ------------------------------------------------------------------------
  // behavioral filter: called once per completed input transfer
  // ------------------------------------------------------------------------
  function automatic void filter_step(input fir_item_t it);
    logic [ACC_W-1:0]    acc;
    longint signed       scaled;
    int unsigned         pos;
    logic [SAMPLE_W-1:0] out_word;
    if (it.mode == MODE_COEF) begin
      // coefficient load, no output; out-of-range taps are dropped
      if (it.coef_index < TAPS) begin
        tap_mem[it.coef_index] = it.coef_value;
      end
      return;
    end
    // circular history, newest slot walks downward
    newest = (newest == 0) ? TAPS - 1 : newest - 1;
    hist_mem[newest] = it.sample;
    acc = '0;
    pos = newest;
    for (int k = 0; k < TAPS; k++) begin
      // 64-bit products summed with plain wraparound
      acc += longint'($signed(hist_mem[pos])) * longint'($signed(tap_mem[k]));
      pos = (pos == TAPS - 1) ? 0 : pos + 1;
    end
    scaled = $signed(acc) >>> COEF_SHIFT;
    if (scaled > Q31_MAX) begin
      out_word = 32'h7FFF_FFFF;
    end else if (scaled < Q31_MIN) begin
      out_word = 32'h8000_0000;
    end else begin
      out_word = scaled[SAMPLE_W-1:0];
    end
    expected_out_q.push_back(out_word);
  endfunction

  function automatic void flag_error(input string what, input logic [31:0] want,
                                     input logic [31:0] got);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("[%0t] error: %s expected %08h actual %08h", $realtime, what, want, got);
    end
  endfunction

  // ------------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------------
  function automatic logic [31:0] pick_word(input int unsigned max_shift);
    logic signed [31:0] raw;
    raw = $urandom;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      // arithmetic shift keeps the sign but spreads the magnitude
      default: return raw >>> $urandom_range(0, max_shift);
    endcase
  endfunction

  function automatic void add_coef(input logic [COEF_IDX_W-1:0] idx,
                                   input logic [COEF_W-1:0] val);
    fir_item_t it;
    it.mode = MODE_COEF;
    it.sample = $urandom;
    it.coef_index = idx;
    it.coef_value = val;
    item_q.push_back(it);
  endfunction

  function automatic void add_sample(input logic [SAMPLE_W-1:0] val);
    fir_item_t it;
    it.mode = MODE_SAMPLE;
    it.sample = val;
    // unused fields still toggle
    it.coef_index = COEF_IDX_W'($urandom);
    it.coef_value = $urandom;
    item_q.push_back(it);
  endfunction

  function automatic void add_random_items(input int unsigned count);
    logic [COEF_IDX_W-1:0] idx;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 18) begin
        // half the writes land on the first taps where fresh samples sit
        idx = $urandom_range(0, 1) ? COEF_IDX_W'($urandom_range(0, TAPS - 1))
                                   : COEF_IDX_W'($urandom_range(0, 15));
        add_coef(idx, pick_word(31));
      end else begin
        add_sample(pick_word(8));
      end
    end
  endfunction

  // nothing queued, nothing on the bus, nothing outstanding
  task automatic wait_drained();
    while (item_q.size() != 0 || s_axis_tvalid || expected_out_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // ------------------------------------------------------------------------
  // input driver: predicts on each completed transfer, then offers the next
  // ------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        filter_step(item_on_bus);
      end
      if (item_q.size() != 0 && $urandom_range(0, 99) >= src_gap_pct) begin
        item_on_bus = item_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= item_on_bus.mode;
        s_axis_tdata <= {{PAD_W{1'b0}}, item_on_bus.coef_value,
                         item_on_bus.coef_index, item_on_bus.sample};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------------
  // output monitor and ready generator
  // ------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_out_q.size() == 0) begin
          flag_error("output with none outstanding,", 32'h0, m_axis_tdata);
        end else if (m_axis_tdata !== expected_out_q[0]) begin
          flag_error("filtered_sample", expected_out_q.pop_front(), m_axis_tdata);
        end else begin
          void'(expected_out_q.pop_front());
        end
      end
      m_axis_tready <= !hold_rx && ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // long output hold-off so the block backs up and drops s_axis_tready
  initial begin
    wait (hold_go);
    @(negedge clk_i);
    hold_rx = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk_i);
    hold_rx = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // sequence: reset, directed cases, three random phases, drain
  // ------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < TAPS; i++) begin
      tap_mem[i] = '0;
      hist_mem[i] = '0;
    end
    newest = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // phase one: sender gaps light, receiver stalls heavy
    src_gap_pct = 26;
    sink_stall_pct = 45;

    // all taps still zero after the clearing sweep
    add_sample(32'h1234_5678);
    // largest tap on full-scale samples, both saturation limits
    add_coef(10'd0, 32'h7FFF_FFFF);
    add_sample(32'h7FFF_FFFF);
    add_sample(32'h8000_0000);
    // four most-negative products add up to 2^64 and wrap to zero
    add_coef(10'd0, 32'h8000_0000);
    add_coef(10'd1, 32'h8000_0000);
    add_coef(10'd2, 32'h8000_0000);
    add_coef(10'd3, 32'h8000_0000);
    add_sample(32'h8000_0000);
    add_sample(32'h8000_0000);
    add_sample(32'h8000_0000);
    // unity pass-through, with the oldest tap in use
    add_coef(10'd0, 32'h1000_0000);
    add_coef(10'd1, 32'h0000_0000);
    add_coef(10'd2, 32'h0000_0000);
    add_coef(10'd3, 32'h0000_0000);
    add_coef(COEF_IDX_W'(TAPS - 1), 32'hF000_0000);
    add_sample(32'h0000_0001);
    add_sample(32'hFFFF_FFFF);
    add_sample(32'h0000_0000);
    add_coef(COEF_IDX_W'(TAPS - 1), 32'h0000_0000);

    add_random_items(187);
    wait_drained();

    // phase two: roles swapped
    src_gap_pct = 45;
    sink_stall_pct = 26;
    add_random_items(187);
    wait_drained();

    // phase three: full rate, plus the long receiver hold-off
    src_gap_pct = 0;
    sink_stall_pct = 0;
    hold_go = 1'b1;
    add_random_items(186);
    wait_drained();

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    while (expected_out_q.size() != 0) begin
      flag_error("missing output,", expected_out_q.pop_front(), 32'h0);
    end

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
